@@ rtl/skts_pkg.sv @@
// Package for the sorted key table search: field widths, op and status codes, item types.
`timescale 1ns / 1ps
package skts_pkg;

  localparam int KEY_W               = 64;
  localparam int OP_W                = 3;
  localparam int POS_W               = 11;
  localparam int STATUS_W            = 2;
  localparam int DEFAULT_TABLE_DEPTH = 1024;

  // op codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
  localparam logic [OP_W-1:0] OP_RANGE  = 3'd3;
  localparam logic [OP_W-1:0] OP_CHECK  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] range_end;
  } query_t;

  typedef struct packed {
    logic                found;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    hit_count;
    logic                is_ordered;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

@@ rtl/sorted_key_table_search.sv @@
// Top level of the sorted key table search: sequencer, shared key comparator and key store.
`timescale 1ns / 1ps
// Keeps a table of up to TABLE_DEPTH signed 64-bit keys appended one at a time and answers
// clear, append, exact search, range query and sorted check on it, one item at a time.
// Every search step goes through the single read port of the key store and one shared
// 64-bit signed comparator: a probe is a memory read, then compare and narrow. A range
// query runs a lower-bound and then an upper-bound search. An append reads the previous
// key, then compares and writes. The next item is taken once the current one has been
// handed to the result register; a result that waits there does not block it. Fields
// position and hit_count are the low 11 bits of the index or count. The key store needs
// no clearing after reset.
module sorted_key_table_search
  import skts_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    query_valid,
  output logic    query_stall,
  input  query_t  query,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APP_WR,
    S_PROBE,
    S_CMP,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    M_EXACT,
    M_LOWER,
    M_UPPER
  } mode_t;

  state_t                  state;
  mode_t                   mode;
  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] end_r;
  logic [CNT_W-1:0]        count;
  logic                    order_flag;
  logic [CNT_W-1:0]        lo;
  logic [CNT_W-1:0]        hi;
  logic [CNT_W-1:0]        mid_r;
  logic [CNT_W-1:0]        lo_res;
  result_t                 work;

  logic                    accept;
  logic                    out_free;
  logic [CNT_W-1:0]        span;
  logic [CNT_W-1:0]        mid;
  logic [CNT_W-1:0]        cnt_prev;
  logic [ADDR_W-1:0]       raddr;
  logic [KEY_W-1:0]        rdata;
  logic signed [KEY_W-1:0] target;
  logic                    rd_lt;
  logic                    rd_eq;
  logic                    app_order;

  // index or count to the 11-bit result field
  function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    return ext[POS_W-1:0];
  endfunction

  assign accept      = query_valid && !query_stall;
  assign query_stall = (state != S_IDLE);
  assign out_free    = !result_valid || !result_stall;

  // probe midpoint: exact search uses the inclusive form, bounds the half-open form
  always_comb begin
    span = hi - lo;
    if (mode == M_EXACT) begin
      mid = lo + ((span - CNT_W'(1)) >> 1);
    end else begin
      mid = lo + (span >> 1);
    end
  end

  // read address: previous key on append, midpoint while searching
  assign cnt_prev = count - CNT_W'(1);
  assign raddr    = (state == S_IDLE) ? cnt_prev[ADDR_W-1:0] : mid[ADDR_W-1:0];

  // shared comparator: stored key against the current target
  assign target = (mode == M_UPPER && state != S_APP_WR) ? end_r : key_r;
  assign rd_lt  = $signed(rdata) < target;
  assign rd_eq  = (rdata == target);

  // order flag after an append: cleared when the new key is below the previous one
  assign app_order = order_flag && !((count != '0) && !rd_lt && !rd_eq);

  skts_key_ram #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (state == S_APP_WR),
    .waddr (count[ADDR_W-1:0]),
    .wdata (key_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sequencer, table state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      order_flag   <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            key_r <= query.key;
            end_r <= query.range_end;
            work  <= '0;
            state <= S_FIN;
            case (query.op)
              OP_CLEAR: begin
                count           <= '0;
                order_flag      <= 1'b1;
                work.is_ordered <= 1'b1;
              end
              OP_APPEND: begin
                if (count == CNT_W'(TABLE_DEPTH)) begin
                  work.status     <= ST_FULL;
                  work.position   <= to_pos(count);
                  work.hit_count  <= to_pos(count);
                  work.is_ordered <= order_flag;
                end else begin
                  state <= S_APP_WR;
                end
              end
              OP_SEARCH, OP_RANGE: begin
                work.is_ordered <= order_flag;
                if (count == '0) begin
                  work.status <= ST_EMPTY;
                end else begin
                  lo    <= '0;
                  hi    <= count;
                  mode  <= (query.op == OP_SEARCH) ? M_EXACT : M_LOWER;
                  state <= S_PROBE;
                end
              end
              OP_CHECK: begin
                if (count <= CNT_W'(1)) begin
                  work.is_ordered <= 1'b1;
                  if (count == '0) begin
                    work.status <= ST_EMPTY;
                  end
                end else begin
                  work.is_ordered <= order_flag;
                  work.hit_count  <= to_pos(count);
                end
              end
              default: begin
              end
            endcase
          end
        end

        // previous key is in rdata; store the new one
        S_APP_WR: begin
          order_flag      <= app_order;
          count           <= count + CNT_W'(1);
          work.position   <= to_pos(count);
          work.hit_count  <= to_pos(count + CNT_W'(1));
          work.is_ordered <= app_order;
          state           <= S_FIN;
        end

        // issue a read at the midpoint, or close the current search
        S_PROBE: begin
          if (lo < hi) begin
            mid_r <= mid;
            state <= S_CMP;
          end else begin
            case (mode)
              M_LOWER: begin
                lo_res <= lo;
                lo     <= '0;
                hi     <= count;
                mode   <= M_UPPER;
              end
              M_UPPER: begin
                work.position  <= to_pos(lo_res);
                work.hit_count <= (lo > lo_res) ? to_pos(lo - lo_res) : '0;
                state          <= S_FIN;
              end
              default: begin
                // exact search missed
                work.found    <= 1'b0;
                work.position <= '0;
                state         <= S_FIN;
              end
            endcase
          end
        end

        // narrow the window on the probed key
        S_CMP: begin
          state <= S_PROBE;
          case (mode)
            M_EXACT: begin
              if (rd_eq) begin
                work.found    <= 1'b1;
                work.position <= to_pos(mid_r);
                state         <= S_FIN;
              end else if (rd_lt) begin
                lo <= mid_r + CNT_W'(1);
              end else begin
                hi <= mid_r;
              end
            end
            M_LOWER: begin
              if (rd_lt) begin
                lo <= mid_r + CNT_W'(1);
              end else begin
                hi <= mid_r;
              end
            end
            default: begin
              if (rd_lt || rd_eq) begin
                lo <= mid_r + CNT_W'(1);
              end else begin
                hi <= mid_r;
              end
            end
          endcase
        end

        // hand the item's result to the output register
        S_FIN: begin
          if (out_free) begin
            result       <= work;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // an accepted item always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted item did not leave idle");

  // a probe always reads inside the filled part of the table
  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (mid_r < count))
    else $error("probe outside the filled entries");

  // an append store grows the count by exactly one
  a_append_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_APP_WR) |=> (count == $past(count) + CNT_W'(1)))
    else $error("append did not advance the entry count");

  // the search window never inverts
  a_window_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (lo <= hi) && (hi <= count))
    else $error("search window out of order");

endmodule

@@ rtl/skts_key_ram.sv @@
// Key store: one write port and one read port with registered read data.
`timescale 1ns / 1ps
module skts_key_ram
  import skts_pkg::*;
#(
  parameter int DEPTH  = DEFAULT_TABLE_DEPTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [KEY_W-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [KEY_W-1:0]  rdata
);

  logic [KEY_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered: data valid in the cycle after the address
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ tb/skts_result_checker.sv @@
// Checker for the sorted key table search: watches both channels, predicts each result, compares.
`timescale 1ns / 1ps
module skts_result_checker
  import skts_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    query_valid,
  input  logic    query_stall,
  input  query_t  query,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      fail_count,
  output int      pending
);

  // shadow copy of the block's state
  longint  stored_keys [TABLE_DEPTH];
  int      stored_count;
  bit      sorted_so_far;
  result_t predicted_answers [$];
  int      failures;

  initial begin
    failures = 0;
    stored_count = 0;
    sorted_so_far = 1'b1;
  end

  // lower bound (upper = 0) or upper bound (upper = 1) over the stored keys
  function automatic int bound_index(longint target, bit upper);
    int l;
    int h;
    int mid;
    bit go_right;
    l = 0;
    h = stored_count;
    while (l < h) begin
      mid = l + (h - l) / 2;
      go_right = upper ? (stored_keys[mid] <= target) : (stored_keys[mid] < target);
      if (go_right) begin
        l = mid + 1;
      end else begin
        h = mid;
      end
    end
    return l;
  endfunction

  // apply one query to the shadow state and return the answer it should give
  function automatic result_t table_step(query_t q);
    result_t r;
    longint  k;
    longint  e;
    int      l;
    int      h;
    int      mid;
    int      lo;
    int      hi;
    bit      hit;
    r = '0;
    k = q.key;
    e = q.range_end;
    case (q.op)
      OP_CLEAR: begin
        stored_count = 0;
        sorted_so_far = 1'b1;
        r.is_ordered = 1'b1;
      end
      OP_APPEND: begin
        if (stored_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
          r.position = POS_W'(stored_count);
        end else begin
          if (stored_count > 0 && k < stored_keys[stored_count - 1]) sorted_so_far = 1'b0;
          stored_keys[stored_count] = k;
          r.position = POS_W'(stored_count);
          stored_count++;
        end
        r.hit_count = POS_W'(stored_count);
        r.is_ordered = sorted_so_far;
      end
      OP_SEARCH: begin
        r.is_ordered = sorted_so_far;
        if (stored_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // first probe that hits wins, order of keys is not checked
          l = 0;
          h = stored_count - 1;
          hit = 1'b0;
          while (l <= h && !hit) begin
            mid = l + (h - l) / 2;
            if (stored_keys[mid] == k) begin
              hit = 1'b1;
              r.found = 1'b1;
              r.position = POS_W'(mid);
            end else if (stored_keys[mid] < k) begin
              l = mid + 1;
            end else begin
              h = mid - 1;
            end
          end
        end
      end
      OP_RANGE: begin
        r.is_ordered = sorted_so_far;
        if (stored_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          lo = bound_index(k, 1'b0);
          hi = bound_index(e, 1'b1);
          r.position = POS_W'(lo);
          // start beyond end clamps to zero
          r.hit_count = (hi > lo) ? POS_W'(hi - lo) : '0;
        end
      end
      OP_CHECK: begin
        if (stored_count <= 1) begin
          r.is_ordered = 1'b1;
          if (stored_count == 0) r.status = ST_EMPTY;
        end else begin
          r.is_ordered = sorted_so_far;
          r.hit_count = POS_W'(stored_count);
        end
      end
      default: begin
        // unused op: all fields stay zero
      end
    endcase
    return r;
  endfunction

  // predict on each accepted query, compare on each accepted result
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      stored_count = 0;
      sorted_so_far = 1'b1;
      predicted_answers.delete();
    end else begin
      if (query_valid && !query_stall) predicted_answers.push_back(table_step(query));
      if (result_valid && !result_stall) begin
        if (predicted_answers.size() == 0) begin
          $error("result item with no query outstanding");
          failures++;
        end else begin
          want = predicted_answers.pop_front();
          if (result.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, result.found);
            failures++;
          end
          if (result.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, result.position);
            failures++;
          end
          if (result.hit_count !== want.hit_count) begin
            $error("hit_count: expected %0d, actual %0d", want.hit_count,
                   result.hit_count);
            failures++;
          end
          if (result.is_ordered !== want.is_ordered) begin
            $error("is_ordered: expected %0d, actual %0d", want.is_ordered, result.is_ordered);
            failures++;
          end
          if (result.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, result.status);
            failures++;
          end
        end
      end
    end
    pending <= predicted_answers.size();
    fail_count <= failures;
  end

endmodule

@@ tb/tb_sorted_key_table_search.sv @@
// Testbench top for the sorted key table search: clock, reset, query and result traffic, verdict.
`timescale 1ns / 1ps
module tb_sorted_key_table_search;
  import skts_pkg::*;

  localparam int     DEPTH        = DEFAULT_TABLE_DEPTH;
  localparam int     ITEM_TOTAL   = 1200;
  localparam int     HOLD_AT      = 300;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     DRAIN_CYCLES = 120;
  localparam int     CYCLE_LIMIT  = 1000000;
  localparam longint KEY_MIN      = 64'h8000_0000_0000_0000;
  localparam longint KEY_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;

  logic    clk = 1'b0;
  logic    rst;
  logic    query_valid;
  logic    query_stall;
  query_t  query;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  int      fail_count;
  int      pending;
  int      cycles = 0;
  int      counted_items = 0;
  bit      idle_off = 1'b0;

  sorted_key_table_search #(.TABLE_DEPTH(DEPTH)) uut (
    .clk          (clk),
    .rst          (rst),
    .query_valid  (query_valid),
    .query_stall  (query_stall),
    .query        (query),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  skts_result_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .query_valid  (query_valid),
    .query_stall  (query_stall),
    .query        (query),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // key mix: full width, small with duplicates, extremes, mid range
  function automatic longint pick_key();
    longint k;
    case ($urandom_range(0, 5))
      0, 1: k = {$urandom, $urandom};
      2, 3: k = longint'($urandom_range(0, 60)) - 30;
      4: begin
        case ($urandom_range(0, 5))
          0: k = KEY_MIN;
          1: k = KEY_MAX;
          2: k = KEY_MIN + 1;
          3: k = KEY_MAX - 1;
          4: k = 0;
          default: k = -1;
        endcase
      end
      default: k = longint'($urandom_range(0, 2000000)) - 1000000;
    endcase
    return k;
  endfunction

  // offer one query item and hold it until the block takes it
  task automatic send_query(input logic [OP_W-1:0] op, input longint k, input longint e);
    int     gap;
    query_t q;
    gap = idle_off ? 0 : $urandom_range(0, 9);
    q.op = op;
    q.key = k;
    q.range_end = e;
    if (gap > 0) begin
      query_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    query <= q;
    query_valid <= 1'b1;
    do @(posedge clk); while (query_stall);
    if (op <= OP_CHECK) counted_items++;
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    int n;
    int got;
    got = 0;
    result_stall = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      n = idle_off ? 0 : $urandom_range(0, 9);
      if (got == HOLD_AT) n = HOLD_CYCLES;
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      got++;
    end
  end

  // stimulus
  initial begin
    longint            keys [$];
    longint            k;
    longint            e;
    logic [OP_W-1:0]   op;
    int                n;
    int                m;
    bit                broken;
    rst = 1'b1;
    query_valid = 1'b0;
    query = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, single entry, extremes, unsorted, hits, misses, clamp
    send_query(OP_CHECK, 0, 0);
    send_query(OP_SEARCH, 5, 0);
    send_query(OP_RANGE, KEY_MIN, KEY_MAX);
    send_query(OP_APPEND, KEY_MIN, KEY_MAX);
    send_query(OP_CHECK, 0, 0);
    send_query(OP_APPEND, KEY_MAX, KEY_MIN);
    send_query(OP_APPEND, 0, -1);
    send_query(OP_CHECK, 0, 0);
    send_query(OP_SEARCH, 0, 0);
    send_query(OP_CLEAR, -1, -1);
    send_query(OP_APPEND, -5, 0);
    send_query(OP_APPEND, -5, 0);
    send_query(OP_APPEND, 7, 0);
    send_query(OP_APPEND, KEY_MAX, 0);
    send_query(OP_SEARCH, -5, 0);
    send_query(OP_SEARCH, 3, 0);
    send_query(OP_SEARCH, KEY_MAX, 0);
    send_query(OP_RANGE, -5, 7);
    send_query(OP_RANGE, 7, -5);
    send_query(OP_RANGE, KEY_MIN, KEY_MAX);
    send_query(OP_CHECK, 0, 0);
    send_query(3'd5, KEY_MAX, KEY_MIN);
    send_query(3'd6, -1, -1);
    send_query(3'd7, KEY_MIN, KEY_MAX);
    send_query(OP_CLEAR, 0, 0);

    // full table: duplicate pairs in order, then appends that are dropped
    for (int i = 0; i < DEPTH; i++) send_query(OP_APPEND, longint'(i / 2) * 5 - 2500, 0);
    send_query(OP_APPEND, pick_key(), pick_key());
    send_query(OP_APPEND, KEY_MAX, 0);
    send_query(OP_APPEND, KEY_MIN, 0);
    send_query(OP_CHECK, 0, 0);
    send_query(OP_SEARCH, -2500, 0);
    send_query(OP_SEARCH, 55, 0);
    send_query(OP_SEARCH, 3, 0);
    send_query(OP_RANGE, KEY_MIN, KEY_MAX);
    send_query(OP_RANGE, 100, 200);
    send_query(OP_RANGE, -100, 100);
    send_query(OP_RANGE, 50, -50);
    send_query(OP_CLEAR, 0, 0);

    // random: mostly small well-formed tables with queries, some noise
    while (counted_items < ITEM_TOTAL) begin
      idle_off = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // noise over all op codes
        repeat (5) begin
          op = OP_W'($urandom_range(0, 7));
          send_query(op, pick_key(), pick_key());
        end
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          send_query(OP_CLEAR, pick_key(), pick_key());
          keys.delete();
        end
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        broken = ($urandom_range(0, 4) == 0);
        begin
          longint fresh [$];
          for (int i = 0; i < n; i++) fresh.push_back(pick_key());
          if (!broken) fresh.sort();
          foreach (fresh[i]) begin
            send_query(OP_APPEND, fresh[i], pick_key());
            keys.push_back(fresh[i]);
          end
        end
        m = $urandom_range(3, 10);
        repeat (m) begin
          if (keys.size() != 0 && $urandom_range(0, 3) != 0) begin
            k = keys[$urandom_range(0, keys.size() - 1)];
            if ($urandom_range(0, 2) == 0) k = k + longint'($urandom_range(0, 4)) - 2;
          end else begin
            k = pick_key();
          end
          case ($urandom_range(0, 4))
            0, 1: send_query(OP_SEARCH, k, pick_key());
            2, 3: begin
              case ($urandom_range(0, 3))
                0: e = pick_key();
                1: e = k - longint'($urandom_range(1, 40));
                2: e = (keys.size() != 0) ? keys[$urandom_range(0, keys.size() - 1)] : k;
                default: e = k + longint'($urandom_range(0, 40));
              endcase
              send_query(OP_RANGE, k, e);
            end
            default: send_query(OP_CHECK, k, pick_key());
          endcase
        end
      end
    end
    idle_off = 1'b0;
    query_valid <= 1'b0;

    // drain, then give late or extra results time to show up
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
